FILE: hdl/assert_macros.svh
// Assertion macros used by the checker file.
// Each macro expects signals named clk and rst_n in the scope where it is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define AST_SAME(lbl, pre, post, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define AST_NEXT(lbl, pre, post, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error(msg);

`endif

FILE: hdl/knn_pkg.sv
// Shared constants, codes and types for the nearest-neighbor classifier.
// No dependencies.
package knn_pkg;

    localparam int FEATURE_COUNT = 4;
    localparam int FEATURE_BITS = 16;
    localparam int LABEL_W = 2;
    localparam int OP_W = 2;
    localparam int STATUS_W = 2;
    localparam int K_CFG_W = 5;
    localparam int CLASS_COUNT = 3;
    localparam int DEF_MAX_SAMPLES = 256;
    localparam int DEF_MAX_K = 16;
    localparam logic [K_CFG_W-1:0] K_RESET = 5'd3;

    localparam logic [OP_W-1:0] OP_LOAD = 2'd0;
    localparam logic [OP_W-1:0] OP_QUERY = 2'd1;
    localparam logic [OP_W-1:0] OP_CLEAR = 2'd2;

    localparam logic [STATUS_W-1:0] ST_OK = 2'd0;
    localparam logic [STATUS_W-1:0] ST_K_EXCEEDS = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL = 2'd2;

    localparam logic [LABEL_W-1:0] LBL_SETOSA = 2'd0;
    localparam logic [LABEL_W-1:0] LBL_VERSICOLOR = 2'd1;
    localparam logic [LABEL_W-1:0] LBL_VIRGINICA = 2'd2;
    localparam logic [LABEL_W-1:0] LBL_OTHER = 2'd3;

    typedef enum logic [2:0] {
        S_IDLE,
        S_RUN,
        S_DRAIN,
        S_VOTE,
        S_RESULT
    } state_t;

endpackage

FILE: hdl/knn_if.sv
// Handshake channels of the classifier: request, response and configuration.
// Depends on knn_pkg.
interface knn_req_if;
    logic valid;
    logic ready;
    logic [knn_pkg::OP_W-1:0] opcode;
    logic [knn_pkg::FEATURE_BITS-1:0] feature_0;
    logic [knn_pkg::FEATURE_BITS-1:0] feature_1;
    logic [knn_pkg::FEATURE_BITS-1:0] feature_2;
    logic [knn_pkg::FEATURE_BITS-1:0] feature_3;
    logic [knn_pkg::LABEL_W-1:0] sample_label;
    modport source (output valid, opcode, feature_0, feature_1, feature_2, feature_3,
                    sample_label, input ready);
    modport sink (input valid, opcode, feature_0, feature_1, feature_2, feature_3,
                  sample_label, output ready);
endinterface

interface knn_rsp_if;
    logic valid;
    logic ready;
    logic [knn_pkg::LABEL_W-1:0] class_guess;
    logic [knn_pkg::STATUS_W-1:0] status;
    modport source (output valid, class_guess, status, input ready);
    modport sink (input valid, class_guess, status, output ready);
endinterface

interface knn_cfg_if;
    logic valid;
    logic ready;
    logic [knn_pkg::K_CFG_W-1:0] data;
    modport source (output valid, data, input ready);
    modport sink (input valid, data, output ready);
endinterface

FILE: hdl/knn_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
// No dependencies.
module knn_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

FILE: hdl/knn_classifier.sv
// k-nearest-neighbor classifier over a sample RAM of MAX_SAMPLES entries with k from 1 to
// MAX_K. Every request word gets exactly one response word. Load, clear and unused words, and
// a query whose k exceeds the stored count, present their response in the cycle right after
// acceptance. An accepted query walks the sample RAM at one read per cycle, and its response
// follows after the RAM read, square and sum stages drain, the votes are counted and the
// class is picked once the output register is free. A new request word is taken
// only once the previous response has left the output register, and k may be written only
// while no word is in flight. Depends on knn_pkg, knn_if and knn_ram.
module knn_classifier #(
    parameter int MAX_SAMPLES = knn_pkg::DEF_MAX_SAMPLES,
    parameter int MAX_K = knn_pkg::DEF_MAX_K
) (
    input logic clk,
    input logic rst_n,
    knn_req_if.sink req,
    knn_rsp_if.source rsp,
    knn_cfg_if.sink cfg
);

    localparam int FC = knn_pkg::FEATURE_COUNT;
    localparam int FB = knn_pkg::FEATURE_BITS;
    localparam int LW = knn_pkg::LABEL_W;
    localparam int AW = $clog2(MAX_SAMPLES);
    localparam int CW = $clog2(MAX_SAMPLES + 1);
    localparam int KW = $clog2(MAX_K + 1);
    localparam int RW = FC * FB + LW;
    localparam int SQ_W = 2 * FB;
    localparam int SUM_W = SQ_W + $clog2(FC);
    localparam int DIST_W = (SUM_W > 64) ? 64 : SUM_W;

    knn_pkg::state_t state_reg, state_next;

    logic [knn_pkg::K_CFG_W-1:0] k_cfg_reg;
    logic [CW-1:0] count_reg, count_next;
    logic [CW-1:0] iss_reg, iss_next;
    logic [KW-1:0] k_reg, k_next;
    logic [KW-1:0] kept_reg, kept_next;
    logic [FC*FB-1:0] query_reg, query_next;
    logic rv_reg, sv_reg, dv_reg;
    logic [SQ_W-1:0] sq_reg [FC];
    logic [SQ_W-1:0] sq_next [FC];
    logic [LW-1:0] lab_s_reg, lab_d_reg;
    logic [DIST_W-1:0] dist_reg, dist_next;
    logic [DIST_W-1:0] near_d_reg [MAX_K];
    logic [DIST_W-1:0] near_d_next [MAX_K];
    logic [LW-1:0] near_l_reg [MAX_K];
    logic [LW-1:0] near_l_next [MAX_K];
    logic [KW-1:0] votes_reg [knn_pkg::CLASS_COUNT];
    logic [KW-1:0] votes_next [knn_pkg::CLASS_COUNT];
    logic out_valid_reg, out_valid_next;
    logic [LW-1:0] guess_reg, guess_next;
    logic [knn_pkg::STATUS_W-1:0] status_reg, status_next;

    logic req_fire;
    logic rd_en;
    logic wr_en;
    logic [RW-1:0] wr_data;
    logic [RW-1:0] rd_data;
    logic [FC*FB-1:0] req_feat;
    logic [KW-1:0] k_eff;
    logic k_too_big;
    logic issue_last;
    logic pipe_empty;
    logic out_free;

    assign req_feat = {req.feature_3, req.feature_2, req.feature_1, req.feature_0};
    assign wr_data = {req.sample_label, req_feat};
    assign req_fire = req.valid && req.ready;
    assign out_free = !out_valid_reg || rsp.ready;
    assign issue_last = (iss_reg == count_reg - CW'(1));
    assign pipe_empty = !rv_reg && !sv_reg && !dv_reg;

    // Zero acts as one, and values above MAX_K saturate.
    always_comb
    begin
        if (k_cfg_reg == '0)
        begin
            k_eff = KW'(1);
        end
        else if (int'(k_cfg_reg) > MAX_K)
        begin
            k_eff = KW'(MAX_K);
        end
        else
        begin
            k_eff = KW'(k_cfg_reg);
        end
        k_too_big = int'(k_eff) > int'(count_reg);
    end

    knn_ram #(
        .WIDTH(RW),
        .DEPTH(MAX_SAMPLES)
    ) u_store (
        .clk(clk),
        .wr_en(wr_en),
        .wr_addr(count_reg[AW-1:0]),
        .wr_data(wr_data),
        .rd_en(rd_en),
        .rd_addr(iss_reg[AW-1:0]),
        .rd_data(rd_data)
    );

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            knn_pkg::S_IDLE:
            begin
                if (req_fire && req.opcode == knn_pkg::OP_QUERY && !k_too_big)
                begin
                    state_next = knn_pkg::S_RUN;
                end
            end
            knn_pkg::S_RUN:
            begin
                if (issue_last)
                begin
                    state_next = knn_pkg::S_DRAIN;
                end
            end
            knn_pkg::S_DRAIN:
            begin
                if (pipe_empty)
                begin
                    state_next = knn_pkg::S_VOTE;
                end
            end
            knn_pkg::S_VOTE:
            begin
                state_next = knn_pkg::S_RESULT;
            end
            knn_pkg::S_RESULT:
            begin
                if (out_free)
                begin
                    state_next = knn_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = knn_pkg::S_IDLE;
            end
        endcase
    end

    // Outputs of the state machine.
    always_comb
    begin
        req.ready = (state_reg == knn_pkg::S_IDLE) && out_free;
        rd_en = (state_reg == knn_pkg::S_RUN);
        wr_en = req_fire && (req.opcode == knn_pkg::OP_LOAD)
                && (int'(count_reg) < MAX_SAMPLES);
        cfg.ready = 1'b1;
        rsp.valid = out_valid_reg;
        rsp.class_guess = guess_reg;
        rsp.status = status_reg;
    end

    // Control datapath: counters, output word and the query latch.
    always_comb
    begin
        count_next = count_reg;
        iss_next = iss_reg;
        k_next = k_reg;
        query_next = query_reg;
        out_valid_next = out_valid_reg && !rsp.ready;
        guess_next = guess_reg;
        status_next = status_reg;

        if (req_fire)
        begin
            guess_next = '0;
            status_next = knn_pkg::ST_OK;
            out_valid_next = 1'b1;
            unique case (req.opcode)
                knn_pkg::OP_LOAD:
                begin
                    if (int'(count_reg) < MAX_SAMPLES)
                    begin
                        count_next = count_reg + CW'(1);
                    end
                    else
                    begin
                        status_next = knn_pkg::ST_FULL;
                    end
                end
                knn_pkg::OP_QUERY:
                begin
                    if (k_too_big)
                    begin
                        status_next = knn_pkg::ST_K_EXCEEDS;
                    end
                    else
                    begin
                        out_valid_next = out_valid_reg && !rsp.ready;
                        iss_next = '0;
                        k_next = k_eff;
                        query_next = req_feat;
                    end
                end
                knn_pkg::OP_CLEAR:
                begin
                    count_next = '0;
                end
                default:
                begin
                end
            endcase
        end

        if (state_reg == knn_pkg::S_RUN)
        begin
            iss_next = iss_reg + CW'(1);
        end

        if (state_reg == knn_pkg::S_RESULT && out_free)
        begin
            out_valid_next = 1'b1;
            status_next = knn_pkg::ST_OK;
            guess_next = near_l_reg[0];
            for (int c = 0; c < knn_pkg::CLASS_COUNT; c++)
            begin
                if (votes_reg[c] > votes_reg[(c + 1) % knn_pkg::CLASS_COUNT]
                    && votes_reg[c] > votes_reg[(c + 2) % knn_pkg::CLASS_COUNT])
                begin
                    guess_next = LW'(c);
                end
            end
        end
    end

    // Distance pipeline: squares of the feature differences, then their sum.
    always_comb
    begin
        logic [FB-1:0] a;
        logic [FB-1:0] b;
        logic [FB-1:0] diff;
        logic [SUM_W-1:0] sum_full;
        for (int f = 0; f < FC; f++)
        begin
            a = query_reg[f*FB +: FB];
            b = rd_data[f*FB +: FB];
            diff = (a > b) ? (a - b) : (b - a);
            sq_next[f] = SQ_W'(diff) * SQ_W'(diff);
        end
        sum_full = '0;
        for (int f = 0; f < FC; f++)
        begin
            sum_full = sum_full + SUM_W'(sq_reg[f]);
        end
        // Sums that cannot fit 64 bits saturate at all ones.
        dist_next = ((sum_full >> DIST_W) != '0) ? '1 : DIST_W'(sum_full);
    end

    // Sorted insertion into the nearest list; earlier samples win ties because
    // only strictly larger entries move down.
    always_comb
    begin
        logic [MAX_K-1:0] ins;
        int pm;
        for (int m = 0; m < MAX_K; m++)
        begin
            ins[m] = ((KW'(m) < kept_reg) && (dist_reg < near_d_reg[m]))
                     || (KW'(m) == kept_reg);
        end
        kept_next = kept_reg;
        for (int m = 0; m < MAX_K; m++)
        begin
            pm = (m == 0) ? 0 : m - 1;
            near_d_next[m] = near_d_reg[m];
            near_l_next[m] = near_l_reg[m];
            if (dv_reg && (KW'(m) < k_reg) && ins[m])
            begin
                if (m == 0 || !ins[pm])
                begin
                    near_d_next[m] = dist_reg;
                    near_l_next[m] = lab_d_reg;
                end
                else
                begin
                    near_d_next[m] = near_d_reg[pm];
                    near_l_next[m] = near_l_reg[pm];
                end
            end
        end
        if (dv_reg && kept_reg < k_reg)
        begin
            kept_next = kept_reg + KW'(1);
        end
        if (req_fire)
        begin
            kept_next = '0;
        end
    end

    // Vote counts over the kept neighbors; label 3 casts no vote.
    always_comb
    begin
        for (int c = 0; c < knn_pkg::CLASS_COUNT; c++)
        begin
            votes_next[c] = '0;
            for (int m = 0; m < MAX_K; m++)
            begin
                if ((KW'(m) < kept_reg) && (near_l_reg[m] == LW'(c)))
                begin
                    votes_next[c] = votes_next[c] + KW'(1);
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= knn_pkg::S_IDLE;
            k_cfg_reg <= knn_pkg::K_RESET;
            count_reg <= '0;
            iss_reg <= '0;
            kept_reg <= '0;
            rv_reg <= 1'b0;
            sv_reg <= 1'b0;
            dv_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg.valid && cfg.ready)
            begin
                k_cfg_reg <= cfg.data;
            end
            count_reg <= count_next;
            iss_reg <= iss_next;
            kept_reg <= kept_next;
            rv_reg <= rd_en;
            sv_reg <= rv_reg;
            dv_reg <= sv_reg;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        k_reg <= k_next;
        query_reg <= query_next;
        sq_reg <= sq_next;
        lab_s_reg <= rd_data[RW-1 -: LW];
        lab_d_reg <= lab_s_reg;
        dist_reg <= dist_next;
        near_d_reg <= near_d_next;
        near_l_reg <= near_l_next;
        if (state_reg == knn_pkg::S_VOTE)
        begin
            votes_reg <= votes_next;
        end
        guess_reg <= guess_next;
        status_reg <= status_next;
    end

endmodule

FILE: hdl/knn_checker.sv
// Port-level checks on the classifier, attached to knn_classifier by bind.
// Depends on knn_pkg and assert_macros.svh.
`include "assert_macros.svh"

module knn_checker (
    input logic clk,
    input logic rst_n,
    input logic req_ready,
    input logic rsp_valid,
    input logic rsp_ready,
    input logic [knn_pkg::LABEL_W-1:0] rsp_class_guess,
    input logic [knn_pkg::STATUS_W-1:0] rsp_status
);

    `AST_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid, "response word dropped")
    `AST_SAME(a_stall_blocks, rsp_valid && !rsp_ready, !req_ready, "request taken while stalled")
    `AST_SAME(a_status_code, rsp_valid, rsp_status == knn_pkg::ST_OK || rsp_status == knn_pkg::ST_K_EXCEEDS || rsp_status == knn_pkg::ST_FULL, "undefined status code")
    `AST_SAME(a_fail_guess, rsp_valid && rsp_status != knn_pkg::ST_OK, rsp_class_guess == '0, "guess set on a failed word")

endmodule

bind knn_classifier knn_checker u_knn_checker (
    .clk(clk),
    .rst_n(rst_n),
    .req_ready(req.ready),
    .rsp_valid(rsp.valid),
    .rsp_ready(rsp.ready),
    .rsp_class_guess(rsp.class_guess),
    .rsp_status(rsp.status)
);

FILE: sim/tb.sv
// Self-checking testbench for the knn_classifier block: loads, clears, queries and unused
// words against a behavioral predictor. Depends on knn_pkg, knn_if and the RTL.
`timescale 1ns / 100ps

module tb;

    localparam int FB = knn_pkg::FEATURE_BITS;
    localparam int LW = knn_pkg::LABEL_W;
    localparam int NS = knn_pkg::DEF_MAX_SAMPLES;
    localparam int NK = knn_pkg::DEF_MAX_K;
    localparam int NF = knn_pkg::FEATURE_COUNT;

    typedef struct packed {
        logic [knn_pkg::OP_W-1:0] opcode;
        logic [FB-1:0] f0;
        logic [FB-1:0] f1;
        logic [FB-1:0] f2;
        logic [FB-1:0] f3;
        logic [LW-1:0] label;
    } sample_word_t;

    typedef struct packed {
        logic [LW-1:0] guess;
        logic [knn_pkg::STATUS_W-1:0] status;
    } answer_t;

    localparam logic [knn_pkg::OP_W-1:0] OP_UNUSED = 2'd3;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    knn_req_if req ();
    knn_rsp_if rsp ();
    knn_cfg_if cfg ();

    knn_classifier dut (
        .clk(clk),
        .rst_n(rst_n),
        .req(req.sink),
        .rsp(rsp.source),
        .cfg(cfg.sink)
    );

    // Predictor state.
    logic [FB-1:0] train_feat [NS][NF];
    logic [LW-1:0] train_label [NS];
    int train_count = 0;
    int k_setting = int'(knn_pkg::K_RESET);

    answer_t expected_answers [$];
    int fail_count = 0;
    int answers_seen = 0;
    int queries_sent = 0;
    int send_idle_pct = 0;
    int recv_stall_pct = 0;

    initial
    begin
        forever #6 clk = ~clk;
    end

    initial
    begin
        #60000000;
        $display("CHECKS FAILED");
        $finish;
    end

    function automatic answer_t predict_answer(sample_word_t w);
        answer_t a;
        int k;
        int kept;
        int pos;
        int votes [4];
        logic [33:0] sq_sum;
        logic [33:0] near_d [NK];
        logic [LW-1:0] near_l [NK];
        logic [FB-1:0] q [NF];
        logic [FB-1:0] diff;
        a = '0;
        q[0] = w.f0; q[1] = w.f1; q[2] = w.f2; q[3] = w.f3;
        if (w.opcode == knn_pkg::OP_LOAD)
        begin
            if (train_count >= NS)
                a.status = knn_pkg::ST_FULL;
            else
            begin
                for (int f = 0; f < NF; f++)
                    train_feat[train_count][f] = q[f];
                train_label[train_count] = w.label;
                train_count++;
            end
        end
        else if (w.opcode == knn_pkg::OP_CLEAR)
            train_count = 0;
        else if (w.opcode == knn_pkg::OP_QUERY)
        begin
            k = (k_setting == 0) ? 1 : (k_setting > NK ? NK : k_setting);
            if (k > train_count)
                a.status = knn_pkg::ST_K_EXCEEDS;
            else
            begin
                kept = 0;
                for (int s = 0; s < train_count; s++)
                begin
                    sq_sum = '0;
                    for (int f = 0; f < NF; f++)
                    begin
                        diff = (q[f] > train_feat[s][f]) ? q[f] - train_feat[s][f]
                                                         : train_feat[s][f] - q[f];
                        sq_sum += 34'(diff) * 34'(diff);
                    end
                    pos = kept;
                    while (pos > 0 && sq_sum < near_d[pos-1])
                        pos--;
                    if (pos < k)
                    begin
                        for (int m = (kept < k ? kept : k - 1); m > pos; m--)
                        begin
                            near_d[m] = near_d[m-1];
                            near_l[m] = near_l[m-1];
                        end
                        near_d[pos] = sq_sum;
                        near_l[pos] = train_label[s];
                        if (kept < k)
                            kept++;
                    end
                end
                votes = '{0, 0, 0, 0};
                for (int m = 0; m < kept; m++)
                    votes[near_l[m]]++;
                if (votes[0] > votes[1] && votes[0] > votes[2])
                    a.guess = knn_pkg::LBL_SETOSA;
                else if (votes[1] > votes[0] && votes[1] > votes[2])
                    a.guess = knn_pkg::LBL_VERSICOLOR;
                else if (votes[2] > votes[0] && votes[2] > votes[1])
                    a.guess = knn_pkg::LBL_VIRGINICA;
                else
                    a.guess = near_l[0];
            end
        end
        return a;
    endfunction

    // The word stays on the bus after acceptance until the next send or an idle cycle
    // replaces it, so valid gets one assignment per falling edge.
    task automatic send_word(sample_word_t w);
        while (send_idle_pct > 0 && $urandom_range(99, 0) < send_idle_pct)
        begin
            req.valid <= 1'b0;
            @(negedge clk);
        end
        req.valid <= 1'b1;
        req.opcode <= w.opcode;
        req.feature_0 <= w.f0;
        req.feature_1 <= w.f1;
        req.feature_2 <= w.f2;
        req.feature_3 <= w.f3;
        req.sample_label <= w.label;
        do
            @(posedge clk);
        while (!req.ready);
        expected_answers.push_back(predict_answer(w));
        if (w.opcode == knn_pkg::OP_QUERY)
            queries_sent++;
        @(negedge clk);
    endtask

    // Queries are a whole walk of the store, so the idle wait is generous.
    task automatic wait_idle();
        req.valid <= 1'b0;
        while (expected_answers.size() != 0)
            @(negedge clk);
        repeat (NS + 20) @(negedge clk);
    endtask

    task automatic write_k(int value);
        wait_idle();
        cfg.valid <= 1'b1;
        cfg.data <= value[knn_pkg::K_CFG_W-1:0];
        do
            @(posedge clk);
        while (!cfg.ready);
        k_setting = value;
        @(negedge clk);
        cfg.valid <= 1'b0;
    endtask

    function automatic sample_word_t make_word(logic [knn_pkg::OP_W-1:0] op,
                                               logic [LW-1:0] lbl, logic [FB-1:0] v);
        sample_word_t w;
        w.opcode = op; w.label = lbl;
        w.f0 = v; w.f1 = v; w.f2 = v; w.f3 = v;
        return w;
    endfunction

    function automatic sample_word_t random_word(logic [knn_pkg::OP_W-1:0] op, int spread);
        sample_word_t w;
        int centre;
        w.opcode = op;
        w.label = LW'($urandom_range(3, 0));
        // Clustered features per label make the votes meaningful; some are full range.
        if (spread == 0)
        begin
            w.f0 = FB'($urandom); w.f1 = FB'($urandom);
            w.f2 = FB'($urandom); w.f3 = FB'($urandom);
        end
        else
        begin
            centre = 16000 * (int'(w.label) + 1);
            w.f0 = FB'(centre + $urandom_range(spread, 0));
            w.f1 = FB'(centre + $urandom_range(spread, 0));
            w.f2 = FB'(centre + $urandom_range(spread, 0));
            w.f3 = FB'(centre + $urandom_range(spread, 0));
        end
        return w;
    endfunction

    // Answer checker.
    always @(posedge clk)
    begin
        answer_t want;
        if (rst_n && rsp.valid && rsp.ready)
        begin
            answers_seen++;
            if (expected_answers.size() == 0)
            begin
                $error("answer word with nothing expected");
                fail_count++;
            end
            else
            begin
                want = expected_answers.pop_front();
                if (rsp.class_guess !== want.guess)
                begin
                    $error("class_guess expected %0d actual %0d", want.guess, rsp.class_guess);
                    fail_count++;
                end
                if (rsp.status !== want.status)
                begin
                    $error("status expected %0d actual %0d", want.status, rsp.status);
                    fail_count++;
                end
            end
        end
    end

    always @(negedge clk)
    begin
        rsp.ready <= !(recv_stall_pct > 0 && $urandom_range(99, 0) < recv_stall_pct);
    end

    task automatic test_directed();
        send_word(make_word(knn_pkg::OP_QUERY, knn_pkg::LBL_SETOSA, 16'h0000));  // empty store
        send_word(make_word(knn_pkg::OP_LOAD, knn_pkg::LBL_SETOSA, 16'h0000));
        send_word(make_word(knn_pkg::OP_LOAD, knn_pkg::LBL_VERSICOLOR, 16'hFFFF));
        send_word(make_word(knn_pkg::OP_LOAD, knn_pkg::LBL_OTHER, 16'h0001));
        send_word(make_word(knn_pkg::OP_LOAD, knn_pkg::LBL_VIRGINICA, 16'h0000));
        send_word(make_word(knn_pkg::OP_QUERY, knn_pkg::LBL_SETOSA, 16'h0000));
        send_word(make_word(knn_pkg::OP_QUERY, knn_pkg::LBL_SETOSA, 16'hFFFF));
        send_word(make_word(OP_UNUSED, knn_pkg::LBL_OTHER, 16'hFFFF));
        write_k(1);
        // The nearest sample carries label 3.
        send_word(make_word(knn_pkg::OP_QUERY, knn_pkg::LBL_SETOSA, 16'h0001));
        write_k(0);
        send_word(make_word(knn_pkg::OP_QUERY, knn_pkg::LBL_SETOSA, 16'h8000));
        write_k(31);
        // k saturates and then exceeds the stored count.
        send_word(make_word(knn_pkg::OP_QUERY, knn_pkg::LBL_SETOSA, 16'h8000));
        send_word(make_word(knn_pkg::OP_CLEAR, knn_pkg::LBL_SETOSA, 16'h0000));
        send_word(make_word(knn_pkg::OP_QUERY, knn_pkg::LBL_SETOSA, 16'h0000));
    endtask

    task automatic test_full_store();
        write_k(16);
        for (int i = 0; i < NS + 3; i++)
            send_word(random_word(knn_pkg::OP_LOAD, (i % 4 == 0) ? 0 : 3000));
        for (int i = 0; i < 6; i++)
            send_word(random_word(knn_pkg::OP_QUERY, 6000));
        send_word(make_word(knn_pkg::OP_CLEAR, knn_pkg::LBL_SETOSA, 16'h0000));
    endtask

    task automatic test_random(int count);
        int r;
        for (int i = 0; i < count; i++)
        begin
            r = $urandom_range(99, 0);
            if (r < 45)
                send_word(random_word(knn_pkg::OP_LOAD, (r < 5) ? 0 : 4000));
            else if (r < 92)
                send_word(random_word(knn_pkg::OP_QUERY, (r < 55) ? 0 : 8000));
            else if (r < 96)
                send_word(random_word(OP_UNUSED, 0));
            else
                send_word(random_word(knn_pkg::OP_CLEAR, 0));
        end
    endtask

    task automatic test_idle_phases();
        int k_values [4] = '{2, 16, 5, 7};
        int idle_mix [4][2] = '{'{0, 0}, '{59, 0}, '{0, 59}, '{17, 17}};
        for (int p = 0; p < 4; p++)
        begin
            write_k(k_values[p]);
            send_idle_pct = idle_mix[p][0];
            recv_stall_pct = idle_mix[p][1];
            test_random(170);
        end
        send_idle_pct = 0;
        recv_stall_pct = 0;
    endtask

    initial
    begin
        req.valid = 1'b0;
        req.opcode = knn_pkg::OP_LOAD;
        req.feature_0 = '0;
        req.feature_1 = '0;
        req.feature_2 = '0;
        req.feature_3 = '0;
        req.sample_label = '0;
        rsp.ready = 1'b1;
        cfg.valid = 1'b0;
        cfg.data = knn_pkg::K_RESET;
        repeat (6) @(negedge clk);
        rst_n = 1'b1;
        test_directed();
        test_full_store();
        test_idle_phases();
        wait_idle();
        $display("Covered %0d answers, %0d queries, k from 0 to 31, full store and clears.",
                 answers_seen, queries_sent);
        if (fail_count == 0 && expected_answers.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end
endmodule

FILE: sim.f
+incdir+hdl
hdl/knn_pkg.sv
hdl/knn_if.sv
hdl/knn_ram.sv
hdl/knn_classifier.sv
hdl/knn_checker.sv
sim/tb.sv
